>>> hdl/siaed_pkg.sv
// ---------------------------------------------------------------------------
// siaed_pkg
// Shared types and constants for the signed ALU with Euclidean divide.
// ---------------------------------------------------------------------------
package siaed_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0]        word_t;
  typedef logic signed [WIDTH-1:0] sword_t;

  localparam word_t ONE = word_t'(1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // control from sequencer to the shift unit
  typedef struct packed {
    logic start;
    logic div;
  } core_ctrl_t;

endpackage

>>> hdl/siaed_req_if.sv
// ---------------------------------------------------------------------------
// siaed_req_if
// Request channel: operation code, two operands and running remainder.
// ---------------------------------------------------------------------------
interface siaed_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  siaed_pkg::sword_t   operand_a;
  siaed_pkg::sword_t   operand_b;
  siaed_pkg::sword_t   remainder_in;

  modport source (
    output valid, operation, operand_a, operand_b, remainder_in,
    input  ready
  );
  modport sink (
    input  valid, operation, operand_a, operand_b, remainder_in,
    output ready
  );
endinterface

>>> hdl/siaed_rsp_if.sv
// ---------------------------------------------------------------------------
// siaed_rsp_if
// Response channel: result, remainder sum and divide-by-zero flag.
// ---------------------------------------------------------------------------
interface siaed_rsp_if;
  logic                valid;
  logic                ready;
  siaed_pkg::sword_t   result;
  siaed_pkg::sword_t   remainder_out;
  logic                div_by_zero;

  modport source (
    output valid, result, remainder_out, div_by_zero,
    input  ready
  );
  modport sink (
    input  valid, result, remainder_out, div_by_zero,
    output ready
  );
endinterface

>>> hdl/signed_int_alu_euclid_div.sv
// ---------------------------------------------------------------------------
// signed_int_alu_euclid_div
// Signed ALU: wrapping add/sub, shift-add multiply, Euclidean divide.
// ---------------------------------------------------------------------------
// Add, subtract and divide by zero go straight to the hand-over state; multiply
//   and divide run the one-bit shift unit, then a sign fix (divide: Euclidean adjust and remainder sum).
// One request at a time: a new request is taken only once the sequencer is back
//   in idle, after the result has gone into the output register.
// Output back-pressure holds the sequencer in its hand-over state.
// Reset (rst_ni, async, active low) empties the sequencer and output register.
// ---------------------------------------------------------------------------
module signed_int_alu_euclid_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  siaed_req_if.sink    req_i,
  siaed_rsp_if.source  rsp_o
);
  import siaed_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,  // kick the shift unit
    S_RUN,    // wait for WIDTH bit steps
    S_MFIX,   // product sign correction
    S_DFIX,   // Euclidean quotient/remainder adjust
    S_DSUM,   // add remainder into running sum
    S_FIN     // hand over to output register
  } state_e;

  state_e     state_q;
  op_e        op_q;
  logic       na_q, nb_q;
  word_t      mag_a_q, mag_b_q;
  word_t      rin_q;
  word_t      res_q;     // staged result
  word_t      rem_q;     // staged remainder sum / Euclidean remainder
  logic       dz_q;
  core_ctrl_t ctrl_q, ctrl_d;

  logic       out_valid_q, out_valid_d;
  word_t      out_res_q, out_rem_q;
  logic       out_dz_q;

  // request side
  word_t      a_w, b_w;
  op_e        req_op;
  logic       accept;
  assign a_w    = word_t'(req_i.operand_a);
  assign b_w    = word_t'(req_i.operand_b);
  assign req_op = op_e'(req_i.operation);
  assign accept = req_i.valid && (state_q == S_IDLE);
  assign req_i.ready = (state_q == S_IDLE);

  // shift unit
  logic  core_done;
  word_t core_lo, core_hi;

  siaed_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_q),
    .mag_a_i (mag_a_q),
    .mag_b_i (mag_b_q),
    .done_o  (core_done),
    .lo_o    (core_lo),
    .hi_o    (core_hi)
  );

  // Euclidean adjust: for a negative dividend with non-zero remainder the
  // quotient moves one step away and the remainder becomes |b| - r.
  logic  sgn_diff, r_adj;
  word_t q_base;
  assign sgn_diff = na_q ^ nb_q;
  assign r_adj    = na_q && (core_hi != '0);
  assign q_base   = sgn_diff ? ~core_lo : core_lo;

  logic out_free;
  assign out_free = !out_valid_q || rsp_o.ready;

  // start pulse for the shift unit, one cycle in S_START
  always_comb begin
    ctrl_d       = '0;
    ctrl_d.start = (state_q == S_START);
    ctrl_d.div   = (state_q == S_START) && (op_q == OP_DIV);
  end

  // output valid: held until taken, set on hand-over
  assign out_valid_d = (out_valid_q && !rsp_o.ready) || ((state_q == S_FIN) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctrl_q      <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_ADD;
      na_q        <= 1'b0;
      nb_q        <= 1'b0;
      dz_q        <= 1'b0;
    end else begin
      ctrl_q      <= ctrl_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= req_op;
            na_q <= a_w[WIDTH-1];
            nb_q <= b_w[WIDTH-1];
            dz_q <= 1'b0;
            case (req_op)
              OP_ADD, OP_SUB: state_q <= S_FIN;
              OP_MUL:         state_q <= S_START;
              OP_DIV: begin
                if (b_w == '0) begin
                  dz_q    <= 1'b1;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_START;
                end
              end
              default:        state_q <= S_FIN;
            endcase
          end
        end
        S_START: state_q <= S_RUN;
        S_RUN: begin
          if (core_done) begin
            state_q <= (op_q == OP_DIV) ? S_DFIX : S_MFIX;
          end
        end
        S_MFIX:  state_q <= S_FIN;
        S_DFIX:  state_q <= S_DSUM;
        S_DSUM:  state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mag_a_q <= a_w[WIDTH-1] ? (~a_w + ONE) : a_w;
          mag_b_q <= b_w[WIDTH-1] ? (~b_w + ONE) : b_w;
          rin_q   <= word_t'(req_i.remainder_in);
          rem_q   <= word_t'(req_i.remainder_in);
          if (req_op == OP_SUB) begin
            res_q <= a_w - b_w;
          end else if (req_op == OP_ADD) begin
            res_q <= a_w + b_w;
          end else begin
            res_q <= '0;
          end
        end
      end
      S_MFIX: begin
        res_q <= sgn_diff ? (~core_lo + ONE) : core_lo;
      end
      S_DFIX: begin
        res_q <= q_base + word_t'(sgn_diff ? !r_adj : r_adj);
        rem_q <= r_adj ? (mag_b_q - core_hi) : core_hi;
      end
      S_DSUM: begin
        rem_q <= rin_q + rem_q;
      end
      S_FIN: begin
        if (out_free) begin
          out_res_q <= res_q;
          out_rem_q <= rem_q;
          out_dz_q  <= dz_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result        = sword_t'(out_res_q);
  assign rsp_o.remainder_out = sword_t'(out_rem_q);
  assign rsp_o.div_by_zero   = out_dz_q;

endmodule

>>> hdl/siaed_core.sv
// ---------------------------------------------------------------------------
// siaed_core
// Bit-serial shift unit: shift-add multiply or restoring divide on
// magnitudes, one bit per cycle, WIDTH bits in all.
// ---------------------------------------------------------------------------
module siaed_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  siaed_pkg::core_ctrl_t ctrl_i,
  input  siaed_pkg::word_t      mag_a_i,
  input  siaed_pkg::word_t      mag_b_i,
  output logic                  done_o,
  output siaed_pkg::word_t      lo_o,
  output siaed_pkg::word_t      hi_o
);
  import siaed_pkg::*;

  logic [WIDTH:0]   acc_q, acc_d;
  word_t            sh_q, sh_d;
  word_t            opd_q, opd_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, div_q, done_q;

  word_t            add_sum;
  logic [WIDTH:0]   trial;
  logic             last;

  assign last    = (cnt_q == CNT_W'(WIDTH - 1));
  assign add_sum = acc_q[WIDTH-1:0] + (sh_q[0] ? opd_q : '0);
  assign trial   = {acc_q[WIDTH-1:0], sh_q[WIDTH-1]} - {1'b0, opd_q};

  always_comb begin
    acc_d = acc_q;
    sh_d  = sh_q;
    opd_d = opd_q;
    if (ctrl_i.start) begin
      acc_d = '0;
      sh_d  = ctrl_i.div ? mag_a_i : mag_b_i;
      opd_d = ctrl_i.div ? mag_b_i : mag_a_i;
    end else if (busy_q) begin
      if (div_q) begin
        // restore on negative trial
        acc_d = trial[WIDTH] ? {1'b0, acc_q[WIDTH-2:0], sh_q[WIDTH-1]} : trial;
        sh_d  = {sh_q[WIDTH-2:0], ~trial[WIDTH]};
      end else begin
        acc_d = {1'b0, add_sum};
        sh_d  = {1'b0, sh_q[WIDTH-1:1]};
        opd_d = {opd_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opd_q <= opd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        div_q  <= ctrl_i.div;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign lo_o   = div_q ? sh_q : acc_q[WIDTH-1:0];
  assign hi_o   = acc_q[WIDTH-1:0];

endmodule
